FILE: rtl/cce_pkg.sv
package cce_pkg;

  localparam int MaxVert = 256;
  localparam int VertW   = $clog2(MaxVert);
  localparam int CntW    = VertW + 1;

  typedef enum logic [1:0] {
    REQ_EDGE   = 2'd0,
    REQ_CLEAR  = 2'd1,
    REQ_MOVE   = 2'd2,
    REQ_REMOVE = 2'd3
  } req_e;

  typedef enum logic [1:0] {
    STAT_OK        = 2'd0,
    STAT_NO_CAND   = 2'd1,
    STAT_OFFSET    = 2'd2,
    STAT_BAD_VERT  = 2'd3
  } stat_e;

  typedef struct packed {
    req_e             req_type;
    logic [VertW-1:0] vertex_a;
    logic [VertW-1:0] vertex_b;
    logic [VertW-1:0] pick_offset;
  } req_t;

  typedef struct packed {
    stat_e            status;
    logic [VertW-1:0] vertex_out;
    logic [CntW-1:0]  clique_size;
    logic [CntW-1:0]  candidate_end;
  } res_t;

  typedef enum logic [4:0] {
    OP_NONE,
    OP_SWEEP,
    OP_CAPTURE,
    OP_CHECK,
    OP_EDGE_RDA,
    OP_EDGE_WRA,
    OP_EDGE_RDB,
    OP_EDGE_WRB,
    OP_MOVE_RD,
    OP_MOVE_GET,
    OP_REM_RD,
    OP_REM_CHK,
    OP_ROW_RD,
    OP_ROW_GET,
    OP_SCAN,
    OP_DEC,
    OP_PLACE2,
    OP_FIN,
    OP_FIN_W1,
    OP_FIN_W2
  } dp_op_e;

  typedef struct packed {
    dp_op_e op;
    logic   clr_adj;
  } dp_cmd_t;

  typedef struct packed {
    req_e req_type;
    logic chk_fail;
    logic rem_bad;
    logic scan_end;
    logic skip;
    logic move;
    logic sweep_done;
  } dp_stat_t;

  typedef enum logic [4:0] {
    S_INIT,
    S_IDLE,
    S_CHECK,
    S_CLEAR,
    S_E_RDA,
    S_E_WRA,
    S_E_RDB,
    S_E_WRB,
    S_M_RD,
    S_M_GET,
    S_R_RD,
    S_R_CHK,
    S_ROW_RD,
    S_ROW_GET,
    S_SCAN,
    S_DEC,
    S_PLACE2,
    S_FIN,
    S_FIN_W1,
    S_FIN_W2,
    S_DONE
  } ctrl_state_e;

endpackage

FILE: rtl/cce_ram.sv
module cce_ram #(
  parameter int Width = 8,
  parameter int Depth = 256,
  localparam int AddrW = $clog2(Depth)
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [AddrW-1:0] waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic [AddrW-1:0] raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    rdata_q <= mem_q[raddr_i];
  end

  assign rdata_o = rdata_q;

endmodule

FILE: rtl/cce_dp.sv
module cce_dp import cce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  input  req_t            req_i,
  input  dp_cmd_t         cmd_i,
  output dp_stat_t        stat_o,
  output res_t            res_o
);

  localparam logic [CntW-1:0] CntMax  = '1;
  localparam logic [CntW-1:0] NMax    = CntW'(MaxVert);

  logic [CntW-1:0]    nv_q, n_eff;
  req_t               req_q;
  logic [CntW-1:0]    ce_q, fe_q, j_q;
  logic [VertW-1:0]   v_q, pv_q, slot_q, sweep_q, vout_q;
  logic [MaxVert-1:0] row_q;
  stat_e              status_q, chk_stat;

  logic               adj_we, vas_we, sov_we, cnt_we;
  logic [VertW-1:0]   adj_waddr, vas_waddr, sov_waddr, cnt_waddr;
  logic [VertW-1:0]   adj_raddr, vas_raddr, sov_raddr;
  logic [MaxVert-1:0] adj_wdata, adj_rd;
  logic [VertW-1:0]   vas_wdata, sov_wdata, vas_rd, sov_rd;
  logic [CntW-1:0]    cnt_wdata, cnt_rd, cnt_new;

  logic               ins, move, place1_en, place2_en, scan_end, skip;
  logic [CntW-1:0]    fe_m1, ce_m1, pick_slot;
  logic [VertW-1:0]   s_scan, s_fin;
  logic [MaxVert-1:0] bit_a, bit_b;

  // effective vertex count, clamped to [1, MaxVert]
  always_comb begin
    if (nv_q == '0) begin
      n_eff = CntW'(1);
    end else if (nv_q > NMax) begin
      n_eff = NMax;
    end else begin
      n_eff = nv_q;
    end
  end

  assign ins       = (req_q.req_type == REQ_MOVE);
  assign fe_m1     = fe_q - CntW'(1);
  assign ce_m1     = ce_q - CntW'(1);
  assign s_scan    = ins ? fe_m1[VertW-1:0] : fe_q[VertW-1:0];
  assign s_fin     = ins ? ce_q[VertW-1:0] : ce_m1[VertW-1:0];
  assign pick_slot = ce_q + CntW'(req_q.pick_offset);
  assign bit_a     = MaxVert'(1) << req_q.vertex_a;
  assign bit_b     = MaxVert'(1) << req_q.vertex_b;

  assign scan_end  = (j_q >= n_eff);
  assign skip      = (j_q == {1'b0, v_q}) || row_q[j_q[VertW-1:0]];

  // conflict count update for the vertex under scan
  always_comb begin
    if (ins) begin
      move    = (cnt_rd == '0) && (fe_q != '0);
      cnt_new = (cnt_rd != CntMax) ? cnt_rd + CntW'(1) : cnt_rd;
    end else begin
      move    = (cnt_rd == CntW'(1)) && (fe_q < n_eff);
      cnt_new = (cnt_rd != '0) ? cnt_rd - CntW'(1) : cnt_rd;
    end
  end

  always_comb begin
    chk_stat = STAT_OK;
    case (req_q.req_type)
      REQ_EDGE: begin
        if ({1'b0, req_q.vertex_a} >= n_eff || {1'b0, req_q.vertex_b} >= n_eff) begin
          chk_stat = STAT_BAD_VERT;
        end
      end
      REQ_MOVE: begin
        if (fe_q <= ce_q) begin
          chk_stat = STAT_NO_CAND;
        end else if ({1'b0, req_q.pick_offset} >= fe_q - ce_q) begin
          chk_stat = STAT_OFFSET;
        end else if (pick_slot >= NMax) begin
          chk_stat = STAT_OFFSET;
        end
      end
      REQ_REMOVE: begin
        if ({1'b0, req_q.vertex_a} >= n_eff) begin
          chk_stat = STAT_BAD_VERT;
        end
      end
      default: chk_stat = STAT_OK;
    endcase
  end

  assign place1_en = ((cmd_i.op == OP_DEC) && move) || (cmd_i.op == OP_FIN_W1);
  assign place2_en = (cmd_i.op == OP_PLACE2) || (cmd_i.op == OP_FIN_W2);

  // memory ports
  always_comb begin
    adj_we    = 1'b0;
    adj_waddr = req_q.vertex_a;
    adj_wdata = adj_rd | bit_b;
    adj_raddr = req_q.vertex_a;
    case (cmd_i.op)
      OP_SWEEP: begin
        adj_we    = cmd_i.clr_adj;
        adj_waddr = sweep_q;
        adj_wdata = '0;
      end
      OP_EDGE_WRA: adj_we = 1'b1;
      OP_EDGE_RDB: adj_raddr = req_q.vertex_b;
      OP_EDGE_WRB: begin
        adj_we    = 1'b1;
        adj_waddr = req_q.vertex_b;
        adj_wdata = adj_rd | bit_a;
      end
      OP_ROW_RD: adj_raddr = v_q;
      default: adj_we = 1'b0;
    endcase
  end

  always_comb begin
    vas_we    = 1'b0;
    vas_waddr = sov_rd;
    vas_wdata = vas_rd;
    sov_we    = 1'b0;
    sov_waddr = vas_rd;
    sov_wdata = sov_rd;
    cnt_we    = 1'b0;
    cnt_waddr = j_q[VertW-1:0];
    cnt_wdata = cnt_new;
    if (cmd_i.op == OP_SWEEP) begin
      vas_we    = 1'b1;
      vas_waddr = sweep_q;
      vas_wdata = sweep_q;
      sov_we    = 1'b1;
      sov_waddr = sweep_q;
      sov_wdata = sweep_q;
      cnt_we    = 1'b1;
      cnt_waddr = sweep_q;
      cnt_wdata = '0;
    end else if (place1_en) begin
      // other vertex goes to the slot that the moved vertex (j or v) held
      vas_we = 1'b1;
      sov_we = 1'b1;
    end else if (place2_en) begin
      vas_we    = 1'b1;
      vas_waddr = slot_q;
      vas_wdata = pv_q;
      sov_we    = 1'b1;
      sov_waddr = pv_q;
      sov_wdata = slot_q;
    end
    if (cmd_i.op == OP_DEC) begin
      cnt_we = 1'b1;
    end
  end

  always_comb begin
    case (cmd_i.op)
      OP_MOVE_RD: vas_raddr = pick_slot[VertW-1:0];
      OP_FIN:     vas_raddr = s_fin;
      default:    vas_raddr = s_scan;
    endcase
    case (cmd_i.op)
      OP_REM_RD: sov_raddr = req_q.vertex_a;
      OP_FIN:    sov_raddr = v_q;
      default:   sov_raddr = j_q[VertW-1:0];
    endcase
  end

  cce_ram #(.Width(MaxVert), .Depth(MaxVert)) u_adj_ram (
    .clk_i  (clk_i),
    .we_i   (adj_we),
    .waddr_i(adj_waddr),
    .wdata_i(adj_wdata),
    .raddr_i(adj_raddr),
    .rdata_o(adj_rd)
  );

  cce_ram #(.Width(VertW), .Depth(MaxVert)) u_vas_ram (
    .clk_i  (clk_i),
    .we_i   (vas_we),
    .waddr_i(vas_waddr),
    .wdata_i(vas_wdata),
    .raddr_i(vas_raddr),
    .rdata_o(vas_rd)
  );

  cce_ram #(.Width(VertW), .Depth(MaxVert)) u_sov_ram (
    .clk_i  (clk_i),
    .we_i   (sov_we),
    .waddr_i(sov_waddr),
    .wdata_i(sov_wdata),
    .raddr_i(sov_raddr),
    .rdata_o(sov_rd)
  );

  cce_ram #(.Width(CntW), .Depth(MaxVert)) u_cnt_ram (
    .clk_i  (clk_i),
    .we_i   (cnt_we),
    .waddr_i(cnt_waddr),
    .wdata_i(cnt_wdata),
    .raddr_i(j_q[VertW-1:0]),
    .rdata_o(cnt_rd)
  );

  // control registers
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      nv_q    <= NMax;
      ce_q    <= '0;
      fe_q    <= NMax;
      j_q     <= '0;
      sweep_q <= '0;
    end else begin
      if (cfg_we_i) begin
        nv_q <= cfg_wdata_i;
      end
      case (cmd_i.op)
        OP_SWEEP: sweep_q <= sweep_q + VertW'(1);
        OP_CHECK: begin
          if (req_q.req_type == REQ_CLEAR) begin
            ce_q <= '0;
            fe_q <= n_eff;
          end
        end
        OP_ROW_GET: j_q <= '0;
        OP_SCAN: begin
          if (!scan_end && skip) begin
            j_q <= j_q + CntW'(1);
          end
        end
        OP_DEC: begin
          if (move) begin
            fe_q <= ins ? fe_m1 : fe_q + CntW'(1);
          end else begin
            j_q <= j_q + CntW'(1);
          end
        end
        OP_PLACE2: j_q <= j_q + CntW'(1);
        OP_FIN: begin
          if (!ins) begin
            ce_q <= ce_m1;
          end
        end
        OP_FIN_W2: begin
          if (ins) begin
            ce_q <= ce_q + CntW'(1);
          end
        end
        default: j_q <= j_q;
      endcase
    end
  end

  // item payload
  always_ff @(posedge clk_i) begin
    case (cmd_i.op)
      OP_CAPTURE: begin
        req_q    <= req_i;
        status_q <= STAT_OK;
        vout_q   <= '0;
      end
      OP_CHECK:    status_q <= chk_stat;
      OP_MOVE_GET: begin
        v_q    <= vas_rd;
        vout_q <= vas_rd;
      end
      OP_REM_CHK: begin
        if ({1'b0, sov_rd} >= ce_q) begin
          status_q <= STAT_BAD_VERT;
        end else begin
          v_q    <= req_q.vertex_a;
          vout_q <= req_q.vertex_a;
        end
      end
      OP_ROW_GET: row_q <= adj_rd;
      OP_SCAN: begin
        slot_q <= s_scan;
        pv_q   <= j_q[VertW-1:0];
      end
      OP_FIN: begin
        slot_q <= s_fin;
        pv_q   <= v_q;
      end
      default: row_q <= row_q;
    endcase
  end

  assign stat_o.req_type   = req_q.req_type;
  assign stat_o.chk_fail   = (chk_stat != STAT_OK);
  assign stat_o.rem_bad    = ({1'b0, sov_rd} >= ce_q);
  assign stat_o.scan_end   = scan_end;
  assign stat_o.skip       = skip;
  assign stat_o.move       = move;
  assign stat_o.sweep_done = &sweep_q;

  assign res_o.status        = status_q;
  assign res_o.vertex_out    = vout_q;
  assign res_o.clique_size   = ce_q;
  assign res_o.candidate_end = fe_q;

endmodule

FILE: rtl/cce_ctrl.sv
module cce_ctrl import cce_pkg::*; (
  input  logic     clk_i,
  input  logic     rst_ni,
  input  logic     start_i,
  input  dp_stat_t stat_i,
  output dp_cmd_t  cmd_o,
  output logic     busy_o,
  output logic     done_o
);

  ctrl_state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_INIT;
    end else begin
      state_q <= state_d;
    end
  end

  always_comb begin
    state_d       = state_q;
    cmd_o.op      = OP_NONE;
    cmd_o.clr_adj = 1'b0;
    busy_o        = 1'b1;
    done_o        = 1'b0;
    case (state_q)
      S_INIT: begin
        cmd_o.op      = OP_SWEEP;
        cmd_o.clr_adj = 1'b1;
        if (stat_i.sweep_done) state_d = S_IDLE;
      end
      S_IDLE: begin
        busy_o = 1'b0;
        if (start_i) begin
          cmd_o.op = OP_CAPTURE;
          state_d  = S_CHECK;
        end
      end
      S_CHECK: begin
        cmd_o.op = OP_CHECK;
        if (stat_i.chk_fail) begin
          state_d = S_DONE;
        end else begin
          case (stat_i.req_type)
            REQ_EDGE:  state_d = S_E_RDA;
            REQ_CLEAR: state_d = S_CLEAR;
            REQ_MOVE:  state_d = S_M_RD;
            default:   state_d = S_R_RD;
          endcase
        end
      end
      S_CLEAR: begin
        cmd_o.op = OP_SWEEP;
        if (stat_i.sweep_done) state_d = S_DONE;
      end
      S_E_RDA: begin
        cmd_o.op = OP_EDGE_RDA;
        state_d  = S_E_WRA;
      end
      S_E_WRA: begin
        cmd_o.op = OP_EDGE_WRA;
        state_d  = S_E_RDB;
      end
      S_E_RDB: begin
        cmd_o.op = OP_EDGE_RDB;
        state_d  = S_E_WRB;
      end
      S_E_WRB: begin
        cmd_o.op = OP_EDGE_WRB;
        state_d  = S_DONE;
      end
      S_M_RD: begin
        cmd_o.op = OP_MOVE_RD;
        state_d  = S_M_GET;
      end
      S_M_GET: begin
        cmd_o.op = OP_MOVE_GET;
        state_d  = S_ROW_RD;
      end
      S_R_RD: begin
        cmd_o.op = OP_REM_RD;
        state_d  = S_R_CHK;
      end
      S_R_CHK: begin
        cmd_o.op = OP_REM_CHK;
        state_d  = stat_i.rem_bad ? S_DONE : S_ROW_RD;
      end
      S_ROW_RD: begin
        cmd_o.op = OP_ROW_RD;
        state_d  = S_ROW_GET;
      end
      S_ROW_GET: begin
        cmd_o.op = OP_ROW_GET;
        state_d  = S_SCAN;
      end
      S_SCAN: begin
        cmd_o.op = OP_SCAN;
        if (stat_i.scan_end) begin
          state_d = S_FIN;
        end else if (!stat_i.skip) begin
          state_d = S_DEC;
        end
      end
      S_DEC: begin
        cmd_o.op = OP_DEC;
        state_d  = stat_i.move ? S_PLACE2 : S_SCAN;
      end
      S_PLACE2: begin
        cmd_o.op = OP_PLACE2;
        state_d  = S_SCAN;
      end
      S_FIN: begin
        cmd_o.op = OP_FIN;
        state_d  = S_FIN_W1;
      end
      S_FIN_W1: begin
        cmd_o.op = OP_FIN_W1;
        state_d  = S_FIN_W2;
      end
      S_FIN_W2: begin
        cmd_o.op = OP_FIN_W2;
        state_d  = S_DONE;
      end
      S_DONE: begin
        done_o  = 1'b1;
        state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

FILE: rtl/clique_candidate_engine.sv
// Clique candidate engine: keeps a local-search clique over a stored graph.
// Command channel: an item (req_i) is taken on a clock edge with start high
// and busy low. Item kinds: load edge, clear, move a free candidate into the
// clique (chosen by offset into the free zone), remove a clique member.
// Result channel: one result per item, shown on res_o for a single cycle
// with res_valid_o high. The receiver cannot stall; it must take it then.
// Config: cfg_we_i writes num_vertices (cfg_wdata_i); write only while idle.
// Steps, from accept to result strobe, with n vertices in use:
//   load edge        two read-modify-writes of adjacency rows
//   clear            sweep of all 256 permutation/count entries
//   move / remove    scan of the non-neighbor row over the n vertices, one
//                    vertex per cycle while neighbors are skipped; each
//                    non-neighbor is held for a count update and any zone move.
//   failed check     no table change before the result strobe.
// busy stays high until the cycle after the strobe; one item in flight.
// Reset: a clearing pass over all 256 entries wipes the adjacency store and sets the
// permutation to identity and all counts to zero; busy is high meanwhile.
// Config writes are taken during that pass as at any other time.
module clique_candidate_engine import cce_pkg::*; (
  input  logic            clk_i,
  input  logic            rst_ni,
  input  logic            start,
  output logic            busy,
  input  req_t            req_i,
  input  logic            cfg_we_i,
  input  logic [CntW-1:0] cfg_wdata_i,
  output logic            res_valid_o,
  output res_t            res_o
);

  dp_cmd_t  cmd;
  dp_stat_t stat;

  // sequencer: one state per datapath step
  cce_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start),
    .stat_i (stat),
    .cmd_o  (cmd),
    .busy_o (busy),
    .done_o (res_valid_o)
  );

  // tables, zone pointers and scan counter
  cce_dp u_dp (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .cfg_we_i   (cfg_we_i),
    .cfg_wdata_i(cfg_wdata_i),
    .req_i      (req_i),
    .cmd_i      (cmd),
    .stat_o     (stat),
    .res_o      (res_o)
  );

  // strobe only comes out of a busy state
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |-> busy)
    else $error("result strobe while idle");

  // a result always returns the engine to idle
  assert property (@(posedge clk_i) disable iff (!rst_ni) res_valid_o |=> !busy)
    else $error("busy after result");

  // accepted item makes the engine busy
  assert property (@(posedge clk_i) disable iff (!rst_ni) (start && !busy) |=> busy)
    else $error("item accepted but not busy");

  // clique zone can never exceed the vertex space
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_valid_o |-> (res_o.clique_size <= CntW'(MaxVert)))
    else $error("clique size out of range");

endmodule

FILE: verif/tb_top.sv
`timescale 1ns / 100ps

module tb_top import cce_pkg::*; ();

  localparam int StallLimit = 20000;

  logic            clk_i       = 1'b0;
  logic            rst_ni      = 1'b0;
  logic            start       = 1'b0;
  logic            busy;
  req_t            req_i       = '0;
  logic            cfg_we_i    = 1'b0;
  logic [CntW-1:0] cfg_wdata_i = '0;
  logic            res_valid_o;
  res_t            res_o;

  clique_candidate_engine i_dut (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start       (start),
    .busy        (busy),
    .req_i       (req_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .res_valid_o (res_valid_o),
    .res_o       (res_o)
  );

  always begin
    #5 clk_i = 1'b1;
    #5 clk_i = 1'b0;
  end

  // ---------------------------------------------------------------------------
  // Shadow of the engine: graph, permutation zones, non-neighbor counts
  // ---------------------------------------------------------------------------
  bit          adj_mx   [MaxVert][MaxVert];
  int unsigned vert_at  [MaxVert];
  int unsigned slot_of  [MaxVert];
  int unsigned conflicts[MaxVert];
  int unsigned clq_end;
  int unsigned cand_end;
  int unsigned nv_reg;

  function automatic int unsigned verts_used();
    if (nv_reg < 1) return 1;
    if (nv_reg > MaxVert) return MaxVert;
    return nv_reg;
  endfunction

  // swap v into slot s, the old owner of s takes v's slot
  function automatic void relocate(int unsigned v, int unsigned s);
    int unsigned other, vs;
    other = vert_at[s];
    vs = slot_of[v];
    vert_at[vs] = other;
    vert_at[s] = v;
    slot_of[other] = vs;
    slot_of[v] = s;
  endfunction

  function automatic void identity_perm();
    for (int i = 0; i < MaxVert; i++) begin
      vert_at[i] = i;
      slot_of[i] = i;
      conflicts[i] = 0;
    end
  endfunction

  function automatic void join_clique(int unsigned v);
    int unsigned n;
    n = verts_used();
    for (int unsigned j = 0; j < n; j++) begin
      if (j == v || adj_mx[v][j]) continue;
      if (conflicts[j] == 0 && cand_end > 0) begin
        cand_end--;
        relocate(j, cand_end);
      end
      if (conflicts[j] < 511) conflicts[j]++;
    end
    relocate(v, clq_end);
    clq_end++;
  endfunction

  function automatic void leave_clique(int unsigned v);
    int unsigned n;
    n = verts_used();
    for (int unsigned j = 0; j < n; j++) begin
      if (j == v || adj_mx[v][j]) continue;
      if (conflicts[j] == 1 && cand_end < n) begin
        relocate(j, cand_end);
        cand_end++;
      end
      if (conflicts[j] > 0) conflicts[j]--;
    end
    clq_end--;
    relocate(v, clq_end);
  endfunction

  function automatic res_t apply_request(req_t r);
    res_t        res;
    int unsigned n, a, b, off, slot;
    n = verts_used();
    a = r.vertex_a;
    b = r.vertex_b;
    off = r.pick_offset;
    res = '0;
    res.status = STAT_OK;
    case (r.req_type)
      REQ_EDGE: begin
        if (a >= n || b >= n) begin
          res.status = STAT_BAD_VERT;
        end else begin
          adj_mx[a][b] = 1'b1;
          adj_mx[b][a] = 1'b1;
        end
      end
      REQ_CLEAR: begin
        identity_perm();
        clq_end = 0;
        cand_end = n;
      end
      REQ_MOVE: begin
        if (cand_end <= clq_end) begin
          res.status = STAT_NO_CAND;
        end else if (off >= cand_end - clq_end) begin
          res.status = STAT_OFFSET;
        end else begin
          slot = clq_end + off;
          if (slot >= MaxVert) begin
            res.status = STAT_OFFSET;
          end else begin
            res.vertex_out = VertW'(vert_at[slot]);
            join_clique(vert_at[slot]);
          end
        end
      end
      default: begin
        if (a >= n || slot_of[a] >= clq_end) begin
          res.status = STAT_BAD_VERT;
        end else begin
          res.vertex_out = VertW'(a);
          leave_clique(a);
        end
      end
    endcase
    res.clique_size = CntW'(clq_end);
    res.candidate_end = CntW'(cand_end);
    return res;
  endfunction

  // ---------------------------------------------------------------------------
  // Driver: one item in flight; random gaps unless a calm stretch is on
  // ---------------------------------------------------------------------------
  req_t pending_items[$];
  res_t expected_results[$];
  bit   calm_mode;
  int   fail_cnt;
  int   quiet_cycles;

  always @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      start <= 1'b0;
    end else begin
      if (start && !busy) expected_results = {expected_results, apply_request(req_i)};
      if (!(start && busy)) begin
        if (pending_items.size() > 0 && (calm_mode || $urandom_range(0, 99) >= 12)) begin
          req_i <= pending_items[0];
          pending_items.delete(0);
          start <= 1'b1;
        end else begin
          start <= 1'b0;
        end
      end
    end
  end

  // Monitor: results cannot be held off, so check every strobe
  always @(posedge clk_i) begin
    if (rst_ni && res_valid_o) begin
      if (expected_results.size() == 0) begin
        $display("%0t: unexpected result %p", $realtime, res_o);
        fail_cnt++;
      end else begin
        res_t exp_r;
        exp_r = expected_results[0];
        expected_results.delete(0);
        if (res_o.status !== exp_r.status)
          $display("%0t: status exp %0d got %0d", $realtime, exp_r.status, res_o.status);
        if (res_o.vertex_out !== exp_r.vertex_out)
          $display("%0t: vertex_out exp %0d got %0d", $realtime, exp_r.vertex_out,
                   res_o.vertex_out);
        if (res_o.clique_size !== exp_r.clique_size)
          $display("%0t: clique_size exp %0d got %0d", $realtime, exp_r.clique_size,
                   res_o.clique_size);
        if (res_o.candidate_end !== exp_r.candidate_end)
          $display("%0t: candidate_end exp %0d got %0d", $realtime, exp_r.candidate_end,
                   res_o.candidate_end);
        if (res_o !== exp_r) fail_cnt++;
      end
    end
  end

  // Watchdog: cycles with neither an accepted item nor a result
  always @(posedge clk_i) begin
    if ((start && !busy) || res_valid_o) begin
      quiet_cycles <= 0;
    end else if (quiet_cycles >= StallLimit) begin
      $display("** clique_candidate_engine: FAILED **");
      $finish;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
  end

  // ---------------------------------------------------------------------------
  // Stimulus
  // ---------------------------------------------------------------------------
  function automatic req_t mk_req(req_e t, int unsigned a, int unsigned b, int unsigned o);
    req_t r;
    r.req_type = t;
    r.vertex_a = VertW'(a);
    r.vertex_b = VertW'(b);
    r.pick_offset = VertW'(o);
    return r;
  endfunction

  // queue one item and wait until it is taken, so the shadow is current
  task automatic issue(req_t r);
    pending_items = {pending_items, r};
    do @(negedge clk_i); while (pending_items.size() > 0 || start);
  endtask

  task automatic drain();
    do @(negedge clk_i); while (pending_items.size() > 0 || start
                                || expected_results.size() > 0 || busy);
    repeat (20) @(negedge clk_i);
  endtask

  task automatic set_vertex_count(int unsigned v);
    drain();
    @(posedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= CntW'(v);
    @(posedge clk_i);
    cfg_we_i <= 1'b0;
    nv_reg = v & 9'h1FF;
  endtask

  // optionally clear, load a graph, then mostly valid moves and removes with some noise
  task automatic search_phase(bit do_clear, int n_edges, int n_steps);
    int unsigned n, pick;
    n = verts_used();
    if (do_clear) issue(mk_req(REQ_CLEAR, $urandom, $urandom, $urandom));
    repeat (n_edges)
      issue(mk_req(REQ_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1), $urandom));
    repeat (n_steps) begin
      pick = $urandom_range(0, 99);
      if (pick < 55 && cand_end > clq_end)
        issue(mk_req(REQ_MOVE, $urandom, $urandom,
                     $urandom_range(0, cand_end - clq_end - 1)));
      else if (pick < 85 && clq_end > 0)
        issue(mk_req(REQ_REMOVE, vert_at[$urandom_range(0, clq_end - 1)], $urandom,
                     $urandom));
      else if (pick < 92)
        issue(mk_req(REQ_EDGE, $urandom_range(0, n - 1), $urandom_range(0, n - 1),
                     $urandom));
      else
        issue(mk_req(req_e'($urandom_range(0, 3)), $urandom, $urandom, $urandom));
    end
  endtask

  initial begin
    fail_cnt = 0;
    quiet_cycles = 0;
    calm_mode = 1'b0;
    for (int i = 0; i < MaxVert; i++)
      for (int j = 0; j < MaxVert; j++) adj_mx[i][j] = 1'b0;
    identity_perm();
    nv_reg = 256;
    clq_end = 0;
    cand_end = 256;
    repeat (8) @(posedge clk_i);
    rst_ni <= 1'b1;

    // directed: widest graph, self loop, extreme ends and offsets
    issue(mk_req(REQ_EDGE, 0, 0, 0));
    issue(mk_req(REQ_EDGE, 255, 255, 255));
    issue(mk_req(REQ_EDGE, 0, 255, 0));
    issue(mk_req(REQ_MOVE, 0, 0, 255));       // last free vertex
    issue(mk_req(REQ_MOVE, 0, 0, 255));       // offset beyond free zone
    issue(mk_req(REQ_REMOVE, 17, 0, 0));      // not a member
    issue(mk_req(REQ_REMOVE, 255, 0, 0));
    issue(mk_req(REQ_CLEAR, 0, 0, 0));

    // tiny graph: bad ends, empty free zone
    set_vertex_count(8);
    issue(mk_req(REQ_CLEAR, 0, 0, 0));
    issue(mk_req(REQ_EDGE, 200, 1, 0));
    issue(mk_req(REQ_EDGE, 1, 8, 0));
    issue(mk_req(REQ_REMOVE, 200, 0, 0));
    set_vertex_count(1);
    issue(mk_req(REQ_CLEAR, 0, 0, 0));
    issue(mk_req(REQ_MOVE, 0, 0, 0));
    issue(mk_req(REQ_MOVE, 0, 0, 0));         // no candidate left
    issue(mk_req(REQ_REMOVE, 0, 0, 0));
    issue(mk_req(REQ_EDGE, 0, 0, 0));

    // random phases over several vertex counts
    set_vertex_count(16);
    search_phase(1, 70, 110);
    set_vertex_count(8);
    search_phase(1, 20, 70);
    set_vertex_count(2);
    search_phase(1, 2, 25);
    calm_mode = 1'b1;
    set_vertex_count(32);
    search_phase(1, 120, 130);
    calm_mode = 1'b0;
    set_vertex_count(24);                     // shrink with a clique held
    search_phase(0, 10, 60);
    set_vertex_count(0);
    search_phase(1, 0, 15);
    set_vertex_count(511);
    search_phase(1, 40, 50);
    set_vertex_count(300);
    search_phase(0, 10, 30);
    set_vertex_count(64);
    search_phase(1, 60, 80);
    set_vertex_count(256);
    search_phase(1, 40, 40);
    set_vertex_count(12);
    search_phase(1, 20, 60);

    drain();
    if (fail_cnt == 0 && expected_results.size() == 0) begin
      $display("** clique_candidate_engine: PASSED **");
    end else begin
      $display("** clique_candidate_engine: FAILED **");
    end
    $finish;
  end

endmodule
